FILE: rtl/core/nns_pkg.sv
package nns_pkg;

  localparam int unsigned RowW      = 10;
  localparam int unsigned AttrW     = 8;
  localparam int unsigned ValW      = 16;
  localparam int unsigned DiffW     = ValW + 1;
  localparam int unsigned SqW       = 2 * DiffW;
  localparam int unsigned DistW     = 48;
  localparam int unsigned AddrW     = RowW + AttrW;
  localparam int unsigned TrainDepth = 1 << AddrW;
  localparam int unsigned AttrDepth  = 1 << AttrW;
  localparam int unsigned CfgDataW  = 11;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [DistW-1:0] DistMax = '1;

  // Input item kinds
  localparam logic KindTrain = 1'b0;
  localparam logic KindTest  = 1'b1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgAttrCount  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTrainCount = 1'b1;

  typedef struct packed {
    logic start;     // clear scan counters and best match
    logic issue;     // read the next training attribute
    logic load_out;  // move the best match into the output register
  } nns_cmd_t;

  typedef struct packed {
    logic trigger;     // the item on the input is the last test attribute
    logic issue_last;  // the current read address is the final one of the scan
    logic pipe_empty;  // no read or square still in flight
    logic out_busy;    // output register holds a result that is not taken
  } nns_status_t;

endpackage

FILE: rtl/core/nns_ctrl.sv
module nns_ctrl
  import nns_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  nns_status_t status_i,
  output nns_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o.start    = 1'b0;
    cmd_o.issue    = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && status_i.trigger) begin
          cmd_o.start = 1'b1;
          state_d     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.issue = 1'b1;
        if (status_i.issue_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status_i.pipe_empty) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/core/nns_datapath.sv
module nns_datapath
  import nns_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_accept_i,
  input  logic                kind_i,
  input  logic [RowW-1:0]     train_row_i,
  input  logic [AttrW-1:0]    attr_index_i,
  input  logic [ValW-1:0]     value_i,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [RowW-1:0]     nearest_row_o,
  output logic [DistW-1:0]    best_distance_o,
  input  nns_cmd_t            cmd_i,
  output nns_status_t         status_o
);

  // Configuration, held as the last index in use
  logic [AttrW-1:0] attr_last_q, attr_last_d;
  logic [RowW-1:0]  row_last_q, row_last_d;
  logic [8:0]       attr_cfg;

  assign attr_cfg = cfg_data_i[8:0];

  always_comb begin
    attr_last_d = attr_last_q;
    row_last_d  = row_last_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CfgAttrCount: begin
          if (attr_cfg == '0) begin
            attr_last_d = '0;
          end else if (attr_cfg > 9'(AttrDepth)) begin
            attr_last_d = '1;
          end else begin
            attr_last_d = AttrW'(attr_cfg - 9'd1);
          end
        end
        CfgTrainCount: begin
          if (cfg_data_i == '0) begin
            row_last_d = '0;
          end else if (cfg_data_i > CfgDataW'(1 << RowW)) begin
            row_last_d = '1;
          end else begin
            row_last_d = RowW'(cfg_data_i - CfgDataW'(1));
          end
        end
        default: ;
      endcase
    end
  end

  // Scan address counters
  logic [RowW-1:0]  row_q, row_d;
  logic [AttrW-1:0] attr_q, attr_d;
  logic             attr_wrap;

  assign attr_wrap = (attr_q == attr_last_q);

  always_comb begin
    row_d  = row_q;
    attr_d = attr_q;
    if (cmd_i.start) begin
      row_d  = '0;
      attr_d = '0;
    end else if (cmd_i.issue) begin
      if (attr_wrap) begin
        attr_d = '0;
        row_d  = row_q + RowW'(1);
      end else begin
        attr_d = attr_q + AttrW'(1);
      end
    end
  end

  // Stores
  logic [ValW-1:0] train_mem [TrainDepth];
  logic [ValW-1:0] test_mem  [AttrDepth];
  logic [ValW-1:0] train_rd_q, test_rd_q;
  logic            wr_train, wr_test;

  assign wr_train = in_accept_i && (kind_i == KindTrain);
  assign wr_test  = in_accept_i && (kind_i == KindTest);

  always_ff @(posedge clk_i) begin
    if (wr_train) begin
      train_mem[{train_row_i, attr_index_i}] <= value_i;
    end
    if (cmd_i.issue) begin
      train_rd_q <= train_mem[{row_q, attr_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_test) begin
      test_mem[attr_index_i] <= value_i;
    end
    if (cmd_i.issue) begin
      test_rd_q <= test_mem[attr_q];
    end
  end

  // Stage 1 tags travel with the read data, stage 2 holds the square
  logic            p1_vld_q, p1_first_q, p1_last_q;
  logic [RowW-1:0] p1_row_q;
  logic            p2_vld_q, p2_first_q, p2_last_q;
  logic [RowW-1:0] p2_row_q;
  logic [SqW-1:0]  p2_sq_q;

  logic signed [DiffW-1:0] diff;
  logic signed [SqW-1:0]   prod;

  assign diff = $signed({test_rd_q[ValW-1], test_rd_q})
              - $signed({train_rd_q[ValW-1], train_rd_q});
  assign prod = diff * diff;

  always_ff @(posedge clk_i) begin
    p1_first_q <= (attr_q == '0);
    p1_last_q  <= attr_wrap;
    p1_row_q   <= row_q;
    p2_first_q <= p1_first_q;
    p2_last_q  <= p1_last_q;
    p2_row_q   <= p1_row_q;
    p2_sq_q    <= SqW'(prod);
  end

  // Accumulate one row and keep the first strictly smallest distance
  logic [DistW-1:0] acc_q, acc_d;
  logic [DistW-1:0] best_sum_q, best_sum_d;
  logic [RowW-1:0]  best_row_q, best_row_d;
  logic [DistW:0]   sum_wide;
  logic [DistW-1:0] sum_sat;

  assign sum_wide = (DistW + 1)'(p2_sq_q)
                  + (p2_first_q ? '0 : {1'b0, acc_q});
  assign sum_sat  = (sum_wide >= {1'b0, DistMax}) ? DistMax : sum_wide[DistW-1:0];

  always_comb begin
    acc_d      = acc_q;
    best_sum_d = best_sum_q;
    best_row_d = best_row_q;
    if (cmd_i.start) begin
      best_sum_d = DistMax;
      best_row_d = '0;
    end else if (p2_vld_q) begin
      acc_d = sum_sat;
      if (p2_last_q && (sum_sat < best_sum_q)) begin
        best_sum_d = sum_sat;
        best_row_d = p2_row_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q      <= acc_d;
    best_sum_q <= best_sum_d;
    best_row_q <= best_row_d;
  end

  // Output register
  logic             out_vld_q, out_vld_d;
  logic [RowW-1:0]  out_row_q;
  logic [DistW-1:0] out_dist_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.load_out) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_row_q  <= best_row_q;
      out_dist_q <= best_sum_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_last_q <= '1;
      row_last_q  <= '1;
      row_q       <= '0;
      attr_q      <= '0;
      p1_vld_q    <= 1'b0;
      p2_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      attr_last_q <= attr_last_d;
      row_last_q  <= row_last_d;
      row_q       <= row_d;
      attr_q      <= attr_d;
      p1_vld_q    <= cmd_i.issue;
      p2_vld_q    <= p1_vld_q;
      out_vld_q   <= out_vld_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign nearest_row_o   = out_row_q;
  assign best_distance_o = out_dist_q;

  assign status_o.trigger    = (kind_i == KindTest) && (attr_index_i == attr_last_q);
  assign status_o.issue_last = attr_wrap && (row_q == row_last_q);
  assign status_o.pipe_empty = !p1_vld_q && !p2_vld_q;
  assign status_o.out_busy   = out_vld_q && !out_ready_i;

endmodule

FILE: rtl/core/nearest_neighbor_search_top.sv
// One-nearest-neighbour search by squared Euclidean distance.
// Input channel (in_valid_i/in_ready_o): kind_i = 0 writes value_i into the
// training store at (train_row_i, attr_index_i); kind_i = 1 writes value_i into
// the test row buffer at attr_index_i. A test attribute at index attr_count-1
// starts a scan over training rows 0 .. train_count-1, reading one attribute a
// cycle from the training store. After the last read, its data pass the square
// and accumulate stages and the best match is then loaded into the output
// register; in_ready_o stays low from the triggering transfer until that load.
// Output channel (out_valid_o/out_ready_i): one transfer per scan carrying the
// first row with the smallest distance and that distance. If the receiver
// stalls, the result waits in the output register and further items are still
// accepted; a following scan holds its result until the register is free.
// Configuration writes (cfg_we_i) must be made only while the block is idle;
// the block itself does not enforce this. Reset sets attr_count to 256 and
// train_count to 1024; the stores are not cleared and hold undefined data
// until written.
module nearest_neighbor_search_top
  import nns_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                kind_i,
  input  logic [RowW-1:0]     train_row_i,
  input  logic [AttrW-1:0]    attr_index_i,
  input  logic [ValW-1:0]     value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [RowW-1:0]     nearest_row_o,
  output logic [DistW-1:0]    best_distance_o
);

  nns_cmd_t    cmd;
  nns_status_t status;

  nns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  nns_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_accept_i     (in_valid_i && in_ready_o),
    .kind_i          (kind_i),
    .train_row_i     (train_row_i),
    .attr_index_i    (attr_index_i),
    .value_i         (value_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .nearest_row_o   (nearest_row_o),
    .best_distance_o (best_distance_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

FILE: rtl/core/nns_checker.sv
module nns_checker
  import nns_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             kind_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [RowW-1:0]  nearest_row_o,
  input logic [DistW-1:0] best_distance_o
);

  // A pending result stays offered until its transfer.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(nearest_row_o) && $stable(best_distance_o))
    else $error("result changed while stalled");

  // Training loads never start a scan.
  a_train_no_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (kind_i == KindTrain) |=> in_ready_o)
    else $error("input stalled after a training load");

  // A new result only appears at the end of a scan, when input was held off.
  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a scan");

endmodule

bind nearest_neighbor_search_top nns_checker u_nns_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .kind_i          (kind_i),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .nearest_row_o   (nearest_row_o),
  .best_distance_o (best_distance_o)
);
